// ===== design/text_console_writer_assert.svh =====
// assertion macros shared by the console writer modules
// each use expects clk in scope; TCW_ASSERT also expects rst_n
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked outside reset only
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define TCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`else

`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;
  localparam int CELLS   = COLUMNS * ROWS;

  // field widths
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ADDR_W  = 11;
  localparam int CELL_W  = COLOR_W + CHAR_W;

  // internal widths
  localparam int RAM_AW = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // codes
  localparam logic              CMD_PUT      = 1'b0;
  localparam logic              CMD_READ     = 1'b1;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_DONE
  } tcw_state_t;

  // controller to datapath
  typedef struct packed {
    logic sweep_clear;
    logic accept;
    logic scroll_clear;
    logic load_out;
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scroll_need;
    logic cnt_row_last;
    logic cnt_all_last;
  } tcw_stat_t;

  // linear screen position to ring buffer address
  function automatic logic [RAM_AW-1:0] phys_addr(input logic [RAM_AW-1:0] lin,
                                                  input logic [RAM_AW-1:0] base);
    logic [RAM_AW:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= (RAM_AW+1)'(CELLS)) begin
      sum = sum - (RAM_AW+1)'(CELLS);
    end
    return sum[RAM_AW-1:0];
  endfunction

endpackage

// ===== design/tcw_if.sv =====
// request channel into the console
interface tcw_in_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_address;
  modport source(output valid, cmd, char_code, cell_address, input ready);
  modport sink(input valid, cmd, char_code, cell_address, output ready);
endinterface

// result channel out of the console
interface tcw_out_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] cursor_position;
  logic [CELL_W-1:0] cell_entry;
  modport source(output valid, cursor_position, cell_entry, input ready);
  modport sink(input valid, cursor_position, cell_entry, output ready);
endinterface

// colour register write channel
interface tcw_cfg_if;
  import tcw_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] text_color;
  modport source(output valid, text_color, input ready);
  modport sink(input valid, text_color, output ready);
endinterface

// ===== design/text_console_writer.sv =====
// put and read requests: each accept leads to ST_DONE, which loads the result register once out_ch is free
// a put that scrolls first passes ST_SCROLL, which writes a blank in the current colour to each cell of the freed row
// no new request is taken until the result register is loaded and the controller is back in ST_IDLE
// reset: synchronous active low; cursor to 0, colour to 7, then a clear pass
// writes grey blanks into every cell while in_ch.ready stays low
module text_console_writer (
  input logic       clk,
  input logic       rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  import tcw_pkg::*;

  tcw_cmd_t  ctl_cmd;
  tcw_stat_t ctl_stat;

  // colour register is always writable
  assign cfg_ch.ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd_o    (ctl_cmd),
    .stat_i   (ctl_stat)
  );

  tcw_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (ctl_cmd),
    .stat_o   (ctl_stat),
    .cfg_we   (cfg_ch.valid),
    .cfg_color(cfg_ch.text_color),
    .in_cmd   (in_ch.cmd),
    .in_char  (in_ch.char_code),
    .in_addr  (in_ch.cell_address),
    .out_pos  (out_ch.cursor_position),
    .out_entry(out_ch.cell_entry)
  );

endmodule

// ===== design/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tcw_ctrl.sv =====
`include "text_console_writer_assert.svh"

module tcw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::tcw_cmd_t  cmd_o,
  input  tcw_pkg::tcw_stat_t stat_i
);

  import tcw_pkg::*;

  tcw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat_i.cnt_all_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = stat_i.scroll_need ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        if (stat_i.cnt_row_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd_o.sweep_clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd_o.accept = in_valid;
      end
      ST_SCROLL: begin
        cmd_o.scroll_clear = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = slot_free;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TCW_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == ST_CLEAR, "reset did not start clearing")
  `TCW_ASSERT(a_no_result_in_clear, state_r == ST_CLEAR |-> !out_valid_r, "result during clear")
  `TCW_ASSERT(a_scroll_entry, cmd_o.accept && stat_i.scroll_need |=> state_r == ST_SCROLL,
              "scroll not started")
  `TCW_ASSERT(a_scroll_exit, state_r == ST_SCROLL && stat_i.cnt_row_last |=> state_r == ST_DONE,
              "scroll did not finish")

endmodule

// ===== design/tcw_dpath.sv =====
`include "text_console_writer_assert.svh"

module tcw_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcw_pkg::tcw_cmd_t            cmd_i,
  output tcw_pkg::tcw_stat_t           stat_o,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_color,
  input  logic                         in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char,
  input  logic [tcw_pkg::ADDR_W-1:0]   in_addr,
  output logic [tcw_pkg::ADDR_W-1:0]   out_pos,
  output logic [tcw_pkg::CELL_W-1:0]   out_entry
);

  import tcw_pkg::*;

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [RAM_AW-1:0]  lin_r, lin_nxt;
  logic [RAM_AW-1:0]  base_r, base_nxt;
  logic [RAM_AW-1:0]  clr_base_r, clr_base_nxt;
  logic [RAM_AW-1:0]  cnt_r, cnt_nxt;
  logic [COLOR_W-1:0] color_r;
  logic               rd_ok_r, rd_ok_nxt;
  logic [ADDR_W-1:0]  out_pos_r;
  logic [CELL_W-1:0]  out_entry_r;

  logic               is_put, is_nl, row_last, col_last, new_row, in_range;
  logic               ram_we, ram_re;
  logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  // request decode
  assign is_put   = cmd_i.accept && (in_cmd == CMD_PUT);
  assign is_nl    = (in_char == NEWLINE_CODE);
  assign row_last = (row_r == ROW_W'(ROWS - 1));
  assign col_last = (col_r == COL_W'(COLUMNS - 1));
  assign new_row  = (in_cmd == CMD_PUT) && (is_nl || col_last);
  assign in_range = (32'(in_addr) < 32'(CELLS));

  // status
  assign stat_o.scroll_need  = new_row && row_last;
  assign stat_o.cnt_row_last = (cnt_r == RAM_AW'(COLUMNS - 1));
  assign stat_o.cnt_all_last = (cnt_r == RAM_AW'(CELLS - 1));

  // cursor, ring base and sweep counter
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    lin_nxt      = lin_r;
    base_nxt     = base_r;
    clr_base_nxt = clr_base_r;
    cnt_nxt      = cnt_r;
    if (cmd_i.sweep_clear || cmd_i.scroll_clear) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (is_put) begin
      if (new_row) begin
        col_nxt = '0;
        if (row_last) begin
          lin_nxt      = RAM_AW'(CELLS - COLUMNS);
          base_nxt     = phys_addr(RAM_AW'(COLUMNS), base_r);
          clr_base_nxt = base_r;
          cnt_nxt      = '0;
        end else begin
          row_nxt = row_r + 1'b1;
          lin_nxt = lin_r - RAM_AW'(col_r) + RAM_AW'(COLUMNS);
        end
      end else begin
        col_nxt = col_r + 1'b1;
        lin_nxt = lin_r + 1'b1;
      end
    end
  end

  // read range flag
  always_comb begin
    rd_ok_nxt = rd_ok_r;
    if (cmd_i.accept) begin
      rd_ok_nxt = (in_cmd == CMD_READ) && in_range;
    end
  end

  // cell store write select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = BLANK_CELL;
    priority if (cmd_i.sweep_clear) begin
      ram_we = 1'b1;
    end else if (cmd_i.scroll_clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_base_r + cnt_r;
      ram_wdata = {color_r, SPACE_CODE};
    end else if (is_put && !is_nl) begin
      ram_we    = 1'b1;
      ram_waddr = phys_addr(lin_r, base_r);
      ram_wdata = {color_r, in_char};
    end
  end

  // cell store read
  assign ram_re    = cmd_i.accept && (in_cmd == CMD_READ) && in_range;
  assign ram_raddr = phys_addr(RAM_AW'(in_addr), base_r);

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      lin_r      <= '0;
      base_r     <= '0;
      clr_base_r <= '0;
      cnt_r      <= '0;
      color_r    <= COLOR_RESET;
      rd_ok_r    <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      lin_r      <= lin_nxt;
      base_r     <= base_nxt;
      clr_base_r <= clr_base_nxt;
      cnt_r      <= cnt_nxt;
      rd_ok_r    <= rd_ok_nxt;
      if (cfg_we) begin
        color_r <= cfg_color;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_pos_r   <= ADDR_W'(lin_r);
      out_entry_r <= rd_ok_r ? ram_rdata : '0;
    end
  end

  assign out_pos   = out_pos_r;
  assign out_entry = out_entry_r;

  `TCW_ASSERT(a_lin_matches, lin_r == RAM_AW'(int'(row_r) * COLUMNS + int'(col_r)),
              "linear cursor out of step with row and column")
  `TCW_ASSERT(a_cursor_bounds, (int'(row_r) < ROWS) && (int'(col_r) < COLUMNS),
              "cursor outside screen")
  `TCW_ASSERT(a_base_bounds, (int'(base_r) < CELLS) && (int'(clr_base_r) < CELLS),
              "ring base outside store")

endmodule
